[src/fcl_pkg.sv]
package fcl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = 5;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;

    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_INSERT      = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_REMOVE_SPAN = 3'd4,
        OP_RESIZE      = 3'd5,
        OP_CLEAR       = 3'd6,
        OP_READ        = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_CAP = 2'd1;
    localparam logic [1:0] ST_POS = 2'd2;

    typedef struct packed {
        t_op                op;
        logic [CNT_W-1:0]   position;
        logic [CNT_W-1:0]   span_end;
        logic [CNT_W-1:0]   amount;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_ctl;

endpackage

[src/fixed_capacity_insert_remove_list_top.sv]
// Ordered list of up to 16 words with push, positional insert, remove at a position or a
// span, drop from the end, resize with fill, clear and read. Every request gives one
// response with the read word, the count after the request, empty and full flags and a
// status. The entries sit in one single-port-write, registered-read memory, so a request
// that moves entries walks them one at a time with a read and then a write for each:
// push, remove-last, clear, a failed request and a request that moves nothing walk no
// entries; read waits for the registered read word; insert and a removal move the
// entries behind the gap; resize writes the fill value into each new slot. A finished
// response waits in an output register, and the next request is taken while it waits.
module fixed_capacity_insert_remove_list_top
    import fcl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_ram_ctl              w_ram;
    logic [DATA_WIDTH-1:0] w_ram_wdata;
    logic [DATA_WIDTH-1:0] w_ram_rdata;
    logic                  w_res_valid;
    t_rsp                  w_res;
    logic                  w_hand;

    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    assign w_hand = !r_rsp_valid || i_rsp_ready;

    fcl_seq #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_ram       (w_ram),
        .o_ram_wdata (w_ram_wdata),
        .i_ram_rdata (w_ram_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_hand)
    );

    fcl_ram #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_ram),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_hand) begin
            r_rsp_valid <= w_res_valid;
        end
        if (w_hand && w_res_valid) begin
            r_rsp <= w_res;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[src/fcl_ram.sv]
module fcl_ram
    import fcl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_ram_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fcl_seq.sv]
module fcl_seq
    import fcl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output t_ram_ctl              o_ram,
    output logic [DATA_WIDTH-1:0] o_ram_wdata,
    input  logic [DATA_WIDTH-1:0] i_ram_rdata,
    output logic                  o_res_valid,
    output t_rsp                  o_res,
    input  logic                  i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_VAL,
        S_DN_RD,
        S_DN_WR,
        S_FILL,
        S_READ
    } t_state;

    t_state                r_state, n_state;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_src, n_src;
    logic [CNT_W-1:0]      r_dst, n_dst;
    logic [CNT_W-1:0]      r_last, n_last;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [1:0]            r_status, n_status;
    logic [VALUE_W-1:0]    r_value, n_value;

    logic                  w_start;
    logic [DATA_WIDTH-1:0] w_in_val;
    logic [CNT_W-1:0]      w_dst_m1;
    logic [CNT_W-1:0]      w_dst_p1;
    logic [CNT_W-1:0]      w_src_p1;
    logic [CNT_W-1:0]      w_span;
    logic [CNT_W-1:0]      w_pos_p1;
    logic                  w_full;

    assign o_req_ready = ((r_state == S_IDLE) && !r_done) || (r_done && i_res_ready);
    assign w_start     = i_req_valid && o_req_ready;
    assign w_in_val    = DATA_WIDTH'(i_req.value);
    assign w_dst_m1    = r_dst - CNT_W'(1);
    assign w_dst_p1    = r_dst + CNT_W'(1);
    assign w_src_p1    = r_src + CNT_W'(1);
    assign w_span      = i_req.span_end - i_req.position;
    assign w_pos_p1    = i_req.position + CNT_W'(1);
    assign w_full      = r_count >= CNT_W'(CAPACITY);

    assign o_res_valid        = r_done;
    assign o_res.read_value   = r_value;
    assign o_res.count        = r_count;
    assign o_res.is_empty     = (r_count == '0);
    assign o_res.is_full      = (r_count == CNT_W'(CAPACITY));
    assign o_res.status       = r_status;

    always_comb begin
        n_state     = r_state;
        n_done      = r_done && !i_res_ready;
        n_count     = r_count;
        n_src       = r_src;
        n_dst       = r_dst;
        n_last      = r_last;
        n_val       = r_val;
        n_status    = r_status;
        n_value     = r_value;
        o_ram       = '0;
        o_ram_wdata = r_val;

        case (r_state)
            S_INS_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = w_dst_m1[ADDR_W-1:0];
                n_state     = S_INS_WR;
            end
            S_INS_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_dst[ADDR_W-1:0];
                o_ram_wdata = i_ram_rdata;
                n_dst       = w_dst_m1;
                n_state     = (w_dst_m1 == r_last) ? S_INS_VAL : S_INS_RD;
            end
            S_INS_VAL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_dst[ADDR_W-1:0];
                n_count     = r_count + CNT_W'(1);
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            S_DN_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_src[ADDR_W-1:0];
                n_state     = S_DN_WR;
            end
            S_DN_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_dst[ADDR_W-1:0];
                o_ram_wdata = i_ram_rdata;
                n_src       = w_src_p1;
                n_dst       = w_dst_p1;
                if (w_src_p1 < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_count = w_dst_p1;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_dst[ADDR_W-1:0];
                n_dst       = w_dst_p1;
                if (w_dst_p1 == r_last) begin
                    n_count = r_last;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_READ: begin
                n_value = VALUE_W'(i_ram_rdata);
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
            end
        endcase

        if (w_start) begin
            n_value  = '0;
            n_status = ST_OK;
            n_val    = w_in_val;
            n_done   = 1'b1;
            n_state  = S_IDLE;
            case (i_req.op)
                OP_PUSH: begin
                    if (w_full) begin
                        n_status = ST_CAP;
                    end else begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_count[ADDR_W-1:0];
                        o_ram_wdata = w_in_val;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_INSERT: begin
                    if (w_full) begin
                        n_status = ST_CAP;
                    end else if (i_req.position > r_count) begin
                        n_status = ST_POS;
                    end else if (i_req.position == r_count) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_count[ADDR_W-1:0];
                        o_ram_wdata = w_in_val;
                        n_count     = r_count + CNT_W'(1);
                    end else begin
                        n_dst   = r_count;
                        n_last  = i_req.position;
                        n_done  = 1'b0;
                        n_state = S_INS_RD;
                    end
                end
                OP_REMOVE_AT, OP_REMOVE_SPAN: begin
                    if (i_req.op == OP_REMOVE_SPAN && i_req.span_end < i_req.position) begin
                        n_status = ST_POS;
                    end else if (i_req.op == OP_REMOVE_SPAN && w_span == '0) begin
                        n_status = ST_OK;
                    end else if (i_req.op == OP_REMOVE_AT || w_span == CNT_W'(1)) begin
                        if (i_req.position == r_count) begin
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end else if (i_req.position > r_count) begin
                            n_status = ST_POS;
                        end else if (w_pos_p1 < r_count) begin
                            n_dst   = i_req.position;
                            n_src   = w_pos_p1;
                            n_done  = 1'b0;
                            n_state = S_DN_RD;
                        end else begin
                            n_count = i_req.position;
                        end
                    end else if (i_req.position >= r_count || i_req.span_end > r_count) begin
                        n_status = ST_POS;
                    end else if (i_req.span_end < r_count) begin
                        n_dst   = i_req.position;
                        n_src   = i_req.span_end;
                        n_done  = 1'b0;
                        n_state = S_DN_RD;
                    end else begin
                        n_count = i_req.position;
                    end
                end
                OP_REMOVE_LAST: begin
                    n_count = (i_req.amount < r_count) ? (r_count - i_req.amount) : '0;
                end
                OP_RESIZE: begin
                    if (i_req.amount > CNT_W'(CAPACITY)) begin
                        n_status = ST_CAP;
                    end else if (i_req.amount <= r_count) begin
                        n_count = i_req.amount;
                    end else begin
                        n_dst   = r_count;
                        n_last  = i_req.amount;
                        n_done  = 1'b0;
                        n_state = S_FILL;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_READ: begin
                    if (i_req.position < r_count) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = i_req.position[ADDR_W-1:0];
                        n_done      = 1'b0;
                        n_state     = S_READ;
                    end else begin
                        n_status = ST_POS;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_last   <= n_last;
        r_val    <= n_val;
        r_status <= n_status;
        r_value  <= n_value;
    end

endmodule
